// ===== hw/rtl/pqt_pkg.sv =====
// pqt_pkg: types and fixed widths for the triangle plane quadric pipeline
// no dependencies; used by pqt_isqrt, pqt_udiv and plane_quadric_from_triangle_unit
package pqt_pkg;

  // fixed widths of the datapath
  localparam int unsigned COORD_W   = 32;  // Q16.16 vertex coordinate
  localparam int unsigned EDGE_W    = 33;  // exact edge difference
  localparam int unsigned PROD_W    = 66;  // exact edge product / cross component
  localparam int unsigned CMAG_W    = 65;  // cross component magnitude
  localparam int unsigned BLEN_W    = 7;   // bit length of a cross magnitude
  localparam int unsigned SHIFT_W   = 6;   // block normalize shift
  localparam int unsigned MAG_W     = 30;  // normalized component magnitude
  localparam int unsigned SQ_W      = 62;  // sum of squares
  localparam int unsigned RES_W     = 63;  // square root working register
  localparam int unsigned LEN_W     = 31;  // normal length
  localparam int unsigned Q_W       = 31;  // unit normal magnitude, Q1.30
  localparam int unsigned NUM_W     = 61;  // dividend of the unit normal
  localparam int unsigned DM_W      = 47;  // plane offset magnitude
  localparam int unsigned SQ_STEPS  = 31;  // one root bit per stage
  localparam int unsigned DIV_STEPS = 31;  // one quotient bit per stage
  localparam int unsigned FRAC_W    = 30;  // fraction bits of the normal

  // input transaction: three vertices
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } pqt_in_t;

  // result transaction: ten quadric coefficients and the degenerate flag
  typedef struct packed {
    logic        [30:0] coef_xx;
    logic signed [31:0] coef_xy;
    logic signed [31:0] coef_xz;
    logic signed [47:0] coef_xw;
    logic        [30:0] coef_yy;
    logic signed [31:0] coef_yz;
    logic signed [47:0] coef_yw;
    logic        [30:0] coef_zz;
    logic signed [47:0] coef_zw;
    logic        [62:0] coef_ww;
    logic               degenerate;
  } pqt_out_t;

  // side data that rides along the normalize pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic [2:0]                neg;
    logic                      deg;
    logic [2:0][MAG_W-1:0]     m;
  } pqt_side_t;

endpackage

// ===== hw/rtl/plane_quadric_from_triangle_unit.sv =====
// plane_quadric_from_triangle_unit: plane error quadric of one triangle, fully pipelined
// depends on pqt_pkg, pqt_isqrt (normal length) and pqt_udiv (unit normal)
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | pqt_in_t  (three Q16.16 vertices)
//   out_    | output    | out_valid / out_ready | pqt_out_t (ten coefficients, degenerate)
//
// one transaction enters per cycle while the output register is empty or taken
// results pass the 31-stage root, one bit per stage, and the 32-stage divider (dividend, then one bit per stage)
// the whole pipeline advances together when the output register is empty or taken
// reset clears all valid bits; payload registers are not reset
module plane_quadric_from_triangle_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pqt_pkg::pqt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pqt_pkg::pqt_out_t out_data
);
  import pqt_pkg::*;

  logic adv;

  // ---------------- stage registers ----------------
  logic                     s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  pqt_side_t                s1_side_r, s2_side_r, s3_side_r, s4_side_r, s5_side_r;
  pqt_side_t                s6_side_r, s7_side_r;
  logic signed [EDGE_W-1:0] e_r [3];
  logic signed [EDGE_W-1:0] f_r [3];
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [PROD_W-1:0] n_r [3];
  logic [CMAG_W-1:0]        cmag_r [3];
  logic [2*MAG_W-1:0]       sq_r [3];
  logic [SQ_W-1:0]          sum_r;

  logic                     sq_vld, dv_vld;
  logic [LEN_W-1:0]         sq_len;
  pqt_side_t                sq_side, dv_side;
  logic [2:0][Q_W-1:0]      dv_q;

  logic                     d1_vld_r, d2_vld_r, d3_vld_r, p1_vld_r, p2_vld_r, out_vld_r;
  logic signed [63:0]       dot_r [3];
  logic signed [65:0]       s_r;
  logic [DM_W-1:0]          dm_r;
  logic [2:0][Q_W-1:0]      d1_q_r, d2_q_r, d3_q_r;
  logic [2:0]               d1_neg_r, d2_neg_r, d3_neg_r, p1_neg_r, p2_neg_r;
  logic                     d1_deg_r, d2_deg_r, d3_deg_r, p1_deg_r, p2_deg_r;
  logic                     d3_dneg_r, p1_dneg_r, p2_dneg_r;
  logic [2*Q_W-1:0]         nn_r [6];
  logic [Q_W+23:0]          ndl_r [3];
  logic [Q_W+22:0]          ndh_r [3];
  logic [47:0]              dll_r;
  logic [46:0]              dlh_r;
  logic [45:0]              dhh_r;
  logic [2*Q_W-1:0]         p2_nn_r [6];
  logic [Q_W+DM_W-1:0]      nd_r [3];
  logic [2*DM_W-1:0]        dd_r;
  pqt_out_t                 out_r;

  // whole pipeline moves when the output register can take a new result
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      d3_vld_r  <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      d1_vld_r  <= dv_vld;
      d2_vld_r  <= d1_vld_r;
      d3_vld_r  <= d2_vld_r;
      p1_vld_r  <= d3_vld_r;
      p2_vld_r  <= p1_vld_r;
      out_vld_r <= p2_vld_r;
    end
  end

  // ---------------- edges ----------------
  logic signed [EDGE_W-1:0] e_nxt [3];
  logic signed [EDGE_W-1:0] f_nxt [3];
  pqt_side_t                s1_side_nxt;

  always_comb begin
    e_nxt[0] = $signed({in_data.bx[31], in_data.bx}) - $signed({in_data.ax[31], in_data.ax});
    e_nxt[1] = $signed({in_data.by[31], in_data.by}) - $signed({in_data.ay[31], in_data.ay});
    e_nxt[2] = $signed({in_data.bz[31], in_data.bz}) - $signed({in_data.az[31], in_data.az});
    f_nxt[0] = $signed({in_data.cx[31], in_data.cx}) - $signed({in_data.ax[31], in_data.ax});
    f_nxt[1] = $signed({in_data.cy[31], in_data.cy}) - $signed({in_data.ay[31], in_data.ay});
    f_nxt[2] = $signed({in_data.cz[31], in_data.cz}) - $signed({in_data.az[31], in_data.az});
    s1_side_nxt    = '0;
    s1_side_nxt.ax = in_data.ax;
    s1_side_nxt.ay = in_data.ay;
    s1_side_nxt.az = in_data.az;
  end

  // ---------------- cross product: products, differences, magnitudes ----------------
  logic [CMAG_W-1:0] cmag_nxt [3];
  logic [2:0]        cneg;
  logic [PROD_W-1:0] nabs;
  pqt_side_t         s4_side_nxt;

  always_comb begin
    nabs = '0;
    for (int i = 0; i < 3; i++) begin
      cneg[i]     = n_r[i][PROD_W-1];
      nabs        = cneg[i] ? PROD_W'(-n_r[i]) : PROD_W'(n_r[i]);
      cmag_nxt[i] = nabs[CMAG_W-1:0];
    end
    s4_side_nxt     = s3_side_r;
    s4_side_nxt.neg = cneg;
  end

  // ---------------- block normalize ----------------
  logic [CMAG_W-1:0]  or_v, shv;
  logic [BLEN_W-1:0]  blen;
  logic [SHIFT_W-1:0] sh;
  pqt_side_t          s5_side_nxt;

  always_comb begin
    or_v = cmag_r[0] | cmag_r[1] | cmag_r[2];
    blen = '0;
    for (int i = 0; i < CMAG_W; i++) begin
      if (or_v[i]) begin
        blen = BLEN_W'(i + 1);
      end
    end
    sh = (blen > BLEN_W'(MAG_W)) ? SHIFT_W'(blen - BLEN_W'(MAG_W)) : '0;
    s5_side_nxt     = s4_side_r;
    s5_side_nxt.deg = (or_v == '0);
    shv             = '0;
    for (int i = 0; i < 3; i++) begin
      shv                = cmag_r[i] >> sh;
      s5_side_nxt.m[i]   = shv[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // edges
      e_r       <= e_nxt;
      f_r       <= f_nxt;
      s1_side_r <= s1_side_nxt;
      // edge products
      p_r[0]    <= e_r[1] * f_r[2];
      p_r[1]    <= e_r[2] * f_r[1];
      p_r[2]    <= e_r[2] * f_r[0];
      p_r[3]    <= e_r[0] * f_r[2];
      p_r[4]    <= e_r[0] * f_r[1];
      p_r[5]    <= e_r[1] * f_r[0];
      s2_side_r <= s1_side_r;
      // cross components
      n_r[0]    <= p_r[0] - p_r[1];
      n_r[1]    <= p_r[2] - p_r[3];
      n_r[2]    <= p_r[4] - p_r[5];
      s3_side_r <= s2_side_r;
      // sign and magnitude
      cmag_r    <= cmag_nxt;
      s4_side_r <= s4_side_nxt;
      // normalize
      s5_side_r <= s5_side_nxt;
      // squares
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= s5_side_r.m[i] * s5_side_r.m[i];
      end
      s6_side_r <= s5_side_r;
      // sum of squares
      sum_r     <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      s7_side_r <= s6_side_r;
    end
  end

  // ---------------- length and unit normal ----------------
  pqt_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s7_vld_r),
    .in_sq    (sum_r),
    .in_side  (s7_side_r),
    .out_valid(sq_vld),
    .out_len  (sq_len),
    .out_side (sq_side)
  );

  pqt_udiv u_udiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (sq_vld),
    .in_len   (sq_len),
    .in_side  (sq_side),
    .out_valid(dv_vld),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // ---------------- plane offset ----------------
  logic signed [31:0] a_s [3];
  logic signed [31:0] vtx [3];
  logic signed [63:0] dot_nxt [3];
  logic [65:0]        smag, srnd;

  always_comb begin
    vtx[0] = dv_side.ax;
    vtx[1] = dv_side.ay;
    vtx[2] = dv_side.az;
    for (int i = 0; i < 3; i++) begin
      a_s[i]     = dv_side.neg[i] ? $signed(-{1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
      dot_nxt[i] = a_s[i] * vtx[i];
    end
    smag = s_r[65] ? 66'(-s_r) : 66'(s_r);
    srnd = smag + 66'd32768;
  end

  // ---------------- coefficient partial products ----------------
  logic [23:0] dl;
  logic [22:0] dh;

  pqt_out_t        out_nxt;
  logic [2*DM_W:0] rdd;
  logic [31:0]     pair_xx, pair_yy, pair_zz;

  assign dl = dm_r[23:0];
  assign dh = dm_r[DM_W-1:24];

  always_ff @(posedge clk) begin
    if (adv) begin
      // signed unit normal times first vertex
      dot_r    <= dot_nxt;
      d1_q_r   <= dv_q;
      d1_neg_r <= dv_side.neg;
      d1_deg_r <= dv_side.deg;
      // dot product
      s_r      <= dot_r[0] + dot_r[1] + dot_r[2];
      d2_q_r   <= d1_q_r;
      d2_neg_r <= d1_neg_r;
      d2_deg_r <= d1_deg_r;
      // rounded offset, sign opposite to the dot product
      dm_r      <= srnd[DM_W+15:16];
      d3_dneg_r <= !s_r[65];
      d3_q_r    <= d2_q_r;
      d3_neg_r  <= d2_neg_r;
      d3_deg_r  <= d2_deg_r;
      // partial products
      nn_r[0] <= d3_q_r[0] * d3_q_r[0];
      nn_r[1] <= d3_q_r[0] * d3_q_r[1];
      nn_r[2] <= d3_q_r[0] * d3_q_r[2];
      nn_r[3] <= d3_q_r[1] * d3_q_r[1];
      nn_r[4] <= d3_q_r[1] * d3_q_r[2];
      nn_r[5] <= d3_q_r[2] * d3_q_r[2];
      for (int i = 0; i < 3; i++) begin
        ndl_r[i] <= d3_q_r[i] * dl;
        ndh_r[i] <= d3_q_r[i] * dh;
      end
      dll_r     <= dl * dl;
      dlh_r     <= dl * dh;
      dhh_r     <= dh * dh;
      p1_neg_r  <= d3_neg_r;
      p1_dneg_r <= d3_dneg_r;
      p1_deg_r  <= d3_deg_r;
      // full products
      p2_nn_r <= nn_r;
      for (int i = 0; i < 3; i++) begin
        nd_r[i] <= (Q_W+DM_W)'(ndl_r[i]) + ((Q_W+DM_W)'(ndh_r[i]) << 24);
      end
      dd_r      <= (2*DM_W)'(dll_r) + ((2*DM_W)'(dlh_r) << 25) + ((2*DM_W)'(dhh_r) << 48);
      p2_neg_r  <= p1_neg_r;
      p2_dneg_r <= p1_dneg_r;
      p2_deg_r  <= p1_deg_r;
      // output register
      out_r     <= out_nxt;
    end
  end

  // ---------------- round, sign and pack ----------------
  function automatic logic [31:0] fix_pair(input logic [2*Q_W-1:0] mag, input logic neg);
    logic [2*Q_W:0] r;
    r = {1'b0, mag} + (2*Q_W+1)'(1 << 29);
    return neg ? 32'(-r[61:30]) : r[61:30];
  endfunction

  function automatic logic [47:0] fix_off(input logic [Q_W+DM_W-1:0] mag, input logic neg);
    logic [Q_W+DM_W:0] r;
    r = {1'b0, mag} + (Q_W+DM_W+1)'(1 << 29);
    return neg ? 48'(-r[77:30]) : r[77:30];
  endfunction

  always_comb begin
    rdd     = {1'b0, dd_r} + (2*DM_W+1)'(1 << 29);
    pair_xx = fix_pair(p2_nn_r[0], 1'b0);
    pair_yy = fix_pair(p2_nn_r[3], 1'b0);
    pair_zz = fix_pair(p2_nn_r[5], 1'b0);
    out_nxt = '0;
    if (p2_deg_r) begin
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.coef_xx = pair_xx[30:0];
      out_nxt.coef_xy = fix_pair(p2_nn_r[1], p2_neg_r[0] ^ p2_neg_r[1]);
      out_nxt.coef_xz = fix_pair(p2_nn_r[2], p2_neg_r[0] ^ p2_neg_r[2]);
      out_nxt.coef_xw = fix_off(nd_r[0], p2_neg_r[0] ^ p2_dneg_r);
      out_nxt.coef_yy = pair_yy[30:0];
      out_nxt.coef_yz = fix_pair(p2_nn_r[4], p2_neg_r[1] ^ p2_neg_r[2]);
      out_nxt.coef_yw = fix_off(nd_r[1], p2_neg_r[1] ^ p2_dneg_r);
      out_nxt.coef_zz = pair_zz[30:0];
      out_nxt.coef_zw = fix_off(nd_r[2], p2_neg_r[2] ^ p2_dneg_r);
      out_nxt.coef_ww = rdd[92:30];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.coef_xx == '0 && out_data.coef_ww == '0)
    else $error("degenerate result with nonzero coefficients");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |-> out_data.coef_xx <= 31'd1073741824)
    else $error("normal component exceeds unit length");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_vld_r)
    else $error("accepted transaction lost at first stage");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid && $stable(out_data))
    else $error("pipeline moved while stalled");

endmodule

// ===== hw/rtl/pqt_isqrt.sv =====
// pqt_isqrt: pipelined integer square root, one root bit per stage
// depends on pqt_pkg; carries pqt_side_t alongside each value
module pqt_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [pqt_pkg::SQ_W-1:0]    in_sq,
  input  pqt_pkg::pqt_side_t          in_side,
  output logic                        out_valid,
  output logic [pqt_pkg::LEN_W-1:0]   out_len,
  output pqt_pkg::pqt_side_t          out_side
);
  import pqt_pkg::*;

  logic [SQ_W-1:0]  rem_r  [SQ_STEPS];
  logic [RES_W-1:0] res_r  [SQ_STEPS];
  pqt_side_t        side_r [SQ_STEPS];
  logic             vld_r  [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQ_W-1:0]  rem_i, rem_nxt;
    logic [RES_W-1:0] res_i, res_nxt, trial;
    pqt_side_t        side_i;
    logic             vld_i;

    if (j == 0) begin : g_first
      assign rem_i  = in_sq;
      assign res_i  = '0;
      assign side_i = in_side;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign res_i  = res_r[j-1];
      assign side_i = side_r[j-1];
      assign vld_i  = vld_r[j-1];
    end

    // trial subtract of the next root bit
    always_comb begin
      trial = res_i + BIT;
      if ({1'b0, rem_i} >= trial) begin
        rem_nxt = rem_i - trial[SQ_W-1:0];
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        rem_nxt = rem_i;
        res_nxt = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        res_r[j]  <= res_nxt;
        side_r[j] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_len   = res_r[SQ_STEPS-1][LEN_W-1:0];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule

// ===== hw/rtl/pqt_udiv.sv =====
// pqt_udiv: three-lane pipelined restoring divider for the unit normal
// depends on pqt_pkg; q = (m * 2^30 + floor(len/2)) / len per lane
module pqt_udiv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [pqt_pkg::LEN_W-1:0]       in_len,
  input  pqt_pkg::pqt_side_t              in_side,
  output logic                            out_valid,
  output logic [2:0][pqt_pkg::Q_W-1:0]    out_q,
  output pqt_pkg::pqt_side_t              out_side
);
  import pqt_pkg::*;

  logic [2:0][Q_W-1:0] rem_r  [DIV_STEPS+1];
  logic [2:0][Q_W-1:0] low_r  [DIV_STEPS+1];
  logic [2:0][Q_W-1:0] q_r    [DIV_STEPS+1];
  logic [LEN_W-1:0]    len_r  [DIV_STEPS+1];
  pqt_side_t           side_r [DIV_STEPS+1];
  logic                vld_r  [DIV_STEPS+1];

  logic [2:0][Q_W-1:0] rem0_nxt, low0_nxt;
  logic [NUM_W-1:0]    num;

  // form the rounded dividend; the top bits already sit below len
  always_comb begin
    num      = '0;
    rem0_nxt = '0;
    low0_nxt = '0;
    for (int l = 0; l < 3; l++) begin
      num         = {1'b0, in_side.m[l], {FRAC_W{1'b0}}} + NUM_W'(in_len >> 1);
      rem0_nxt[l] = {1'b0, num[NUM_W-1:Q_W]};
      low0_nxt[l] = num[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem0_nxt;
      low_r[0]  <= low0_nxt;
      q_r[0]    <= '0;
      len_r[0]  <= in_len;
      side_r[0] <= in_side;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    logic [2:0][Q_W-1:0] rem_nxt, low_nxt, q_nxt;
    logic [Q_W:0]        t, diff;
    logic                ge;

    // one quotient bit per lane
    always_comb begin
      t    = '0;
      diff = '0;
      ge   = 1'b0;
      for (int l = 0; l < 3; l++) begin
        t          = {rem_r[j-1][l], low_r[j-1][l][Q_W-1]};
        diff       = t - {1'b0, len_r[j-1]};
        ge         = (t >= {1'b0, len_r[j-1]});
        rem_nxt[l] = ge ? diff[Q_W-1:0] : t[Q_W-1:0];
        low_nxt[l] = low_r[j-1][l] << 1;
        q_nxt[l]   = {q_r[j-1][l][Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        low_r[j]  <= low_nxt;
        q_r[j]    <= q_nxt;
        len_r[j]  <= len_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS];
  assign out_q     = q_r[DIV_STEPS];
  assign out_side  = side_r[DIV_STEPS];

endmodule
